[hdl/mwc_pkg.sv]
// mwc_pkg: shared types, widths, register indexes and reset values of the
// motion wake-up controller. No dependencies; used by every hdl file.
package mwc_pkg;

	localparam int TICK_W         = 12;  // tick period, seconds
	localparam int TH_W           = 24;  // timer thresholds, seconds
	localparam int CNT_W          = 8;   // motion count
	localparam int MV_W           = 12;  // supply voltage, mV
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 24;
	localparam int TIMER_BITS_DEF = 24;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TICK_PERIOD    = 3'd0,
		REG_KEEP_ALIVE     = 3'd1,
		REG_START_THRESH   = 3'd2,
		REG_STOP_THRESH    = 3'd3,
		REG_INACT_ENABLE   = 3'd4,
		REG_INACT_THRESH   = 3'd5,
		REG_SUPPLY_MIN     = 3'd6
	} reg_idx_t;

	localparam logic [TICK_W-1:0] RST_TICK_PERIOD  = 12'd60;
	localparam logic [TH_W-1:0]   RST_KEEP_ALIVE   = 24'd86400;
	localparam logic [CNT_W-1:0]  RST_START_THRESH = 8'd5;
	localparam logic [TH_W-1:0]   RST_STOP_THRESH  = 24'd300;
	localparam logic              RST_INACT_ENABLE = 1'b0;
	localparam logic [TH_W-1:0]   RST_INACT_THRESH = 24'd86400;
	localparam logic [MV_W-1:0]   RST_SUPPLY_MIN   = 12'd1500;

	typedef struct packed {
		logic [TICK_W-1:0] tick_period_s;
		logic [TH_W-1:0]   keep_alive_period_s;
		logic [CNT_W-1:0]  start_threshold_irqs;
		logic [TH_W-1:0]   stop_threshold_s;
		logic              inactivity_enable;
		logic [TH_W-1:0]   inactivity_threshold_s;
		logic [MV_W-1:0]   supply_min_mv;
	} cfg_t;

	typedef struct packed {
		logic            tick;
		logic            motion;
		logic [MV_W-1:0] supply_mv;
	} item_t;

	typedef struct packed {
		logic wake;
		logic low_power;
		logic fix_request;
		logic moving;
		logic alarm;
	} res_t;

endpackage

[hdl/mwc_cfg_regs.sv]
// mwc_cfg_regs: configuration register file of the motion wake-up controller.
// Depends on mwc_pkg for the register indexes, reset values and cfg_t.
module mwc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [mwc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [mwc_pkg::CFG_DATA_W-1:0]   wr_data,
	output mwc_pkg::cfg_t                    cfg
);

	mwc_pkg::cfg_t cfg_q;

	// out-of-range values keep their low bits; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period_s          <= mwc_pkg::RST_TICK_PERIOD;
			cfg_q.keep_alive_period_s    <= mwc_pkg::RST_KEEP_ALIVE;
			cfg_q.start_threshold_irqs   <= mwc_pkg::RST_START_THRESH;
			cfg_q.stop_threshold_s       <= mwc_pkg::RST_STOP_THRESH;
			cfg_q.inactivity_enable      <= mwc_pkg::RST_INACT_ENABLE;
			cfg_q.inactivity_threshold_s <= mwc_pkg::RST_INACT_THRESH;
			cfg_q.supply_min_mv          <= mwc_pkg::RST_SUPPLY_MIN;
		end else if (wr_en) begin
			case (wr_index)
				mwc_pkg::REG_TICK_PERIOD:
					cfg_q.tick_period_s <= wr_data[mwc_pkg::TICK_W-1:0];
				mwc_pkg::REG_KEEP_ALIVE:
					cfg_q.keep_alive_period_s <= wr_data[mwc_pkg::TH_W-1:0];
				mwc_pkg::REG_START_THRESH:
					cfg_q.start_threshold_irqs <= wr_data[mwc_pkg::CNT_W-1:0];
				mwc_pkg::REG_STOP_THRESH:
					cfg_q.stop_threshold_s <= wr_data[mwc_pkg::TH_W-1:0];
				mwc_pkg::REG_INACT_ENABLE:
					cfg_q.inactivity_enable <= wr_data[0];
				mwc_pkg::REG_INACT_THRESH:
					cfg_q.inactivity_threshold_s <= wr_data[mwc_pkg::TH_W-1:0];
				mwc_pkg::REG_SUPPLY_MIN:
					cfg_q.supply_min_mv <= wr_data[mwc_pkg::MV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/mwc_step.sv]
// mwc_step: tracker state registers and the combinational wake decision.
// Depends on mwc_pkg for cfg_t, item_t, res_t and field widths.
module mwc_step #(
	parameter int TIMER_BITS = mwc_pkg::TIMER_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  mwc_pkg::item_t item,
	input  mwc_pkg::cfg_t  cfg,
	output mwc_pkg::res_t  res
);

	localparam int SW = ((TIMER_BITS > mwc_pkg::TICK_W) ? TIMER_BITS : mwc_pkg::TICK_W) + 1;
	localparam int CW = (TIMER_BITS > mwc_pkg::TH_W) ? TIMER_BITS : mwc_pkg::TH_W;
	localparam logic [SW-1:0] TMAX = {{(SW-TIMER_BITS){1'b0}}, {TIMER_BITS{1'b1}}};

	logic [TIMER_BITS-1:0]     fix_timer_q, alive_timer_q, quiet_timer_q;
	logic [mwc_pkg::CNT_W-1:0] motion_count_q;
	logic                      moving_q, alarm_q, accel_on_q;

	logic [TIMER_BITS-1:0]     fix_timer_d, alive_timer_d, quiet_timer_d;
	logic [mwc_pkg::CNT_W-1:0] motion_count_d;
	logic                      moving_d, alarm_d, accel_on_d;

	logic [TIMER_BITS-1:0]     fix_t1, alive_t1, quiet_t1;
	logic [mwc_pkg::CNT_W-1:0] cnt_t1;
	logic                      counted, wake, low_power, fix;

	function automatic logic [TIMER_BITS-1:0] sat_add(
		input logic [TIMER_BITS-1:0]     t,
		input logic [mwc_pkg::TICK_W-1:0] inc
	);
		logic [SW-1:0] s;
		s = SW'(t) + SW'(inc);
		return (s > TMAX) ? TMAX[TIMER_BITS-1:0] : s[TIMER_BITS-1:0];
	endfunction

	always_comb begin
		// tick: advance timers, decay motion count
		fix_t1   = item.tick ? sat_add(fix_timer_q, cfg.tick_period_s) : fix_timer_q;
		alive_t1 = item.tick ? sat_add(alive_timer_q, cfg.tick_period_s) : alive_timer_q;
		quiet_t1 = item.tick ? sat_add(quiet_timer_q, cfg.tick_period_s) : quiet_timer_q;
		cnt_t1   = (item.tick && motion_count_q != '0) ? motion_count_q - 1'b1
			: motion_count_q;
		wake     = 1'b0;
		alarm_d  = alarm_q;
		moving_d = moving_q;
		quiet_timer_d  = quiet_t1;
		motion_count_d = cnt_t1;
		if (item.tick && CW'(alive_t1) >= CW'(cfg.keep_alive_period_s)) begin
			alarm_d = 1'b0;
			wake    = 1'b1;
		end

		// motion counts only with the accelerometer on
		counted = item.motion && accel_on_q;
		if (counted) begin
			if (cnt_t1 != mwc_pkg::CNT_MAX)
				motion_count_d = cnt_t1 + 1'b1;
			quiet_timer_d = '0;
			if (!moving_q && motion_count_d > cfg.start_threshold_irqs) begin
				moving_d = 1'b1;
				alarm_d  = 1'b1;
				wake     = 1'b1;
			end
		end else if (moving_q && CW'(quiet_t1) >= CW'(cfg.stop_threshold_s)) begin
			moving_d = 1'b0;
			alarm_d  = 1'b1;
			wake     = 1'b1;
		end

		low_power     = wake && (item.supply_mv < cfg.supply_min_mv);
		fix           = wake && !low_power && ((!moving_d && alarm_d) ||
			(cfg.inactivity_enable && CW'(fix_t1) >= CW'(cfg.inactivity_threshold_s)));
		accel_on_d    = wake ? !low_power : accel_on_q;
		fix_timer_d   = fix ? '0 : fix_t1;
		alive_timer_d = wake ? '0 : alive_t1;
		if (wake) begin
			motion_count_d = '0;
			quiet_timer_d  = '0;
		end

		res.wake        = wake;
		res.low_power   = low_power;
		res.fix_request = fix;
		res.moving      = moving_d;
		res.alarm       = alarm_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_timer_q    <= '0;
			alive_timer_q  <= '0;
			quiet_timer_q  <= '0;
			motion_count_q <= '0;
			moving_q       <= 1'b0;
			alarm_q        <= 1'b0;
			accel_on_q     <= 1'b1;
		end else if (advance) begin
			fix_timer_q    <= fix_timer_d;
			alive_timer_q  <= alive_timer_d;
			quiet_timer_q  <= quiet_timer_d;
			motion_count_q <= motion_count_d;
			moving_q       <= moving_d;
			alarm_q        <= alarm_d;
			accel_on_q     <= accel_on_d;
		end
	end

`ifndef SYNTH
	a_fix_needs_wake: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.fix_request |-> res.wake && !res.low_power)
		else $error("fix request without full-power wake");

	a_wake_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.wake |=> motion_count_q == '0 && quiet_timer_q == '0 &&
			alive_timer_q == '0)
		else $error("counters not cleared after wake");

	a_accel_follows_power: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.wake |=> accel_on_q == !$past(res.low_power))
		else $error("accelerometer state does not follow power mode");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(fix_timer_q) && $stable(alive_timer_q) &&
			$stable(quiet_timer_q) && $stable(motion_count_q) && $stable(moving_q) &&
			$stable(alarm_q) && $stable(accel_on_q))
		else $error("state changed without a request");
`endif

endmodule

[hdl/motion_wakeup_controller.sv]
// motion_wakeup_controller: top level, input and result registers around the step.
// Depends on mwc_pkg, mwc_cfg_regs and mwc_step.
//
// One request is one wake from sleep (tick, motion, supply_mv); each gives
// exactly one result (wake, low_power, fix_request, moving, alarm). A
// request lands in an input register, the state update and wake decision
// are done in the single step stage, and the result sits in a result
// register until taken; each request thus passes both registers.
// Throughput is one request per cycle while results are taken, as the
// step stage updates the state combinationally (each wake depends on the
// state the previous one left). A stalled result holds the step stage,
// and the input register then fills before in_ready drops.
// Configuration writes are always accepted (cfg_ready high) and take effect
// on the next cycle; write only while no request is in flight. Register
// index i is the i-th register: tick period, keep-alive period, start
// threshold, stop threshold, inactivity enable, inactivity threshold,
// supply minimum. Unknown indexes are ignored; wide data keeps its low bits.
module motion_wakeup_controller #(
	parameter int TIMER_BITS = mwc_pkg::TIMER_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mwc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mwc_pkg::CFG_DATA_W-1:0] cfg_data,
	// wake requests
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           tick,
	input  logic                           motion,
	input  logic [mwc_pkg::MV_W-1:0]       supply_mv,
	// results
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           wake,
	output logic                           low_power,
	output logic                           fix_request,
	output logic                           moving,
	output logic                           alarm
);

	mwc_pkg::cfg_t  cfg;
	mwc_pkg::item_t item_s1;
	mwc_pkg::res_t  res, res_s2;
	logic           valid_s1, valid_s2, advance;

	assign cfg_ready = 1'b1;

	mwc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// step stage fires when a request is held and the result slot frees
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.tick      <= tick;
			item_s1.motion    <= motion;
			item_s1.supply_mv <= supply_mv;
		end
		if (advance)
			res_s2 <= res;
	end

	mwc_step #(
		.TIMER_BITS (TIMER_BITS)
	) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	assign out_valid   = valid_s2;
	assign wake        = res_s2.wake;
	assign low_power   = res_s2.low_power;
	assign fix_request = res_s2.fix_request;
	assign moving      = res_s2.moving;
	assign alarm       = res_s2.alarm;

endmodule
